>>> rtl/core/ppsu_pkg.sv
// ----------------------------------------------------------------------------
// ppsu_pkg
// Shared types and constants of the perspective projection unit.
// ----------------------------------------------------------------------------
package ppsu_pkg;

   localparam int PROD_W   = 64;   // exact product of a coefficient and a coordinate
   localparam int WORD_W   = 32;
   localparam int SIZE_W   = 13;
   localparam int QUOT_W   = 16;   // one overflow bit and fifteen quotient bits
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_LO = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X_HI = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_LO = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y_HI = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_W_LO = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_W_HI = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 4'd7;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

   // Control and result bits that travel down the divider chain with a point.
   typedef struct packed {
      logic              valid;
      logic              visible;
      logic              neg_x;
      logic              neg_y;
      logic [QUOT_W-1:0] quot_x;
      logic [QUOT_W-1:0] quot_y;
      logic [WORD_W-1:0] clip_w;
   } cell_ctl_type;

endpackage

>>> rtl/core/ppsu_div_cell.sv
// ----------------------------------------------------------------------------
// ppsu_div_cell
// One restoring-division cell: settles one quotient bit for both pixel axes.
// ----------------------------------------------------------------------------
module ppsu_div_cell #(
   parameter int RW  = 66,
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  ppsu_pkg::cell_ctl_type ctl_in,
   input  logic [RW-1:0]          rem_x_in,
   input  logic [RW-1:0]          rem_y_in,
   input  logic [RW-1:0]          den_in,
   output ppsu_pkg::cell_ctl_type ctl_out,
   output logic [RW-1:0]          rem_x_out,
   output logic [RW-1:0]          rem_y_out,
   output logic [RW-1:0]          den_out
);
   import ppsu_pkg::*;

   cell_ctl_type  ctl_ff, ctl_in_n;
   logic [RW-1:0] rem_x_ff, rem_x_in_n, rem_y_ff, rem_y_in_n, den_ff;
   logic [RW-1:0] trial;
   logic          ge_x, ge_y;

   always_comb begin
      trial      = den_in << BIT;
      ge_x       = rem_x_in >= trial;
      ge_y       = rem_y_in >= trial;
      ctl_in_n   = ctl_in;
      ctl_in_n.quot_x[BIT] = ge_x;
      ctl_in_n.quot_y[BIT] = ge_y;
      rem_x_in_n = ge_x ? rem_x_in - trial : rem_x_in;
      rem_y_in_n = ge_y ? rem_y_in - trial : rem_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_in_n;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= rem_x_in_n;
         rem_y_ff <= rem_y_in_n;
         den_ff   <= den_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign rem_x_out = rem_x_ff;
   assign rem_y_out = rem_y_ff;
   assign den_out   = den_ff;

endmodule

>>> rtl/core/ppsu_front.sv
// ----------------------------------------------------------------------------
// ppsu_front
// Matrix products, clip coordinates and divider operands, five stages deep.
// ----------------------------------------------------------------------------
module ppsu_front #(
   parameter int FRAC_BITS        = 16,
   parameter int NEAR_W_THRESHOLD = 7,
   parameter int RW               = 82 - FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [2:0][31:0]        point,
   input  logic [2:0][1:0][63:0]   coef,
   input  logic [12:0]             width,
   input  logic [12:0]             height,
   output ppsu_pkg::cell_ctl_type  ctl_out,
   output logic [RW-1:0]           rem_x_out,
   output logic [RW-1:0]           rem_y_out,
   output logic [RW-1:0]           den_out
);
   import ppsu_pkg::*;

   localparam int DOT_W = PROD_W + 2 - FRAC_BITS;
   localparam int NUM_W = DOT_W + 1;
   localparam int NW    = NUM_W + SIZE_W + 1;
   localparam logic signed [DOT_W-1:0] NEAR_V = DOT_W'(NEAR_W_THRESHOLD);
   localparam logic signed [DOT_W-1:0] W_MAX  = DOT_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [DOT_W-1:0] W_MIN  = -DOT_W'(33'sh0_8000_0000);

   // Column order: 0 is x, 1 is y, 2 is w.
   logic [4:0]               valid_ff;
   logic signed [31:0]       pt_ff [3];
   logic signed [63:0]       prod_ff [3][3];
   logic signed [DOT_W-1:0]  dot_ff [3], dot_in [3];
   logic                     vis_ff, vis_e_ff;
   logic signed [NUM_W-1:0]  nx_ff, ny_ff;
   logic [NUM_W-1:0]         den_d_ff;
   logic [31:0]              clip_ff, clip_e_ff, clip_in;
   logic signed [NW-1:0]     big_x, big_y;
   logic [RW-1:0]            rem_x_ff, rem_y_ff, den_ff;
   logic                     neg_x_ff, neg_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dot_in[c] = DOT_W'(prod_ff[c][0] >>> FRAC_BITS)
                   + DOT_W'(prod_ff[c][1] >>> FRAC_BITS)
                   + DOT_W'(prod_ff[c][2] >>> FRAC_BITS)
                   + DOT_W'($signed(coef[c][1][63:32]));
      end
      if (dot_ff[2] > W_MAX) begin
         clip_in = 32'h7FFF_FFFF;
      end else if (dot_ff[2] < W_MIN) begin
         clip_in = 32'h8000_0000;
      end else begin
         clip_in = dot_ff[2][31:0];
      end
      big_x = $signed({1'b0, width}) * nx_ff;
      big_y = $signed({1'b0, height}) * ny_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            pt_ff[r] <= $signed(point[r]);
         end
         for (int c = 0; c < 3; c++) begin
            prod_ff[c][0] <= $signed(coef[c][0][31:0])  * pt_ff[0];
            prod_ff[c][1] <= $signed(coef[c][0][63:32]) * pt_ff[1];
            prod_ff[c][2] <= $signed(coef[c][1][31:0])  * pt_ff[2];
            dot_ff[c]     <= dot_in[c];
         end
         vis_ff    <= dot_ff[2] >= NEAR_V;
         nx_ff     <= NUM_W'(dot_ff[2]) + NUM_W'(dot_ff[0]);
         ny_ff     <= NUM_W'(dot_ff[2]) - NUM_W'(dot_ff[1]);
         den_d_ff  <= {dot_ff[2][DOT_W-2:0], 2'b00} >> 1;
         clip_ff   <= clip_in;
         // A negative numerator is divided as its complement; the quotient is
         // complemented back at the end, which gives the floor.
         neg_x_ff  <= big_x[NW-1];
         neg_y_ff  <= big_y[NW-1];
         rem_x_ff  <= RW'($unsigned(big_x[NW-1] ? ~big_x : big_x));
         rem_y_ff  <= RW'($unsigned(big_y[NW-1] ? ~big_y : big_y));
         den_ff    <= RW'(den_d_ff);
         vis_e_ff  <= vis_ff;
         clip_e_ff <= clip_ff;
      end
   end

   always_comb begin
      ctl_out         = '0;
      ctl_out.valid   = valid_ff[4];
      ctl_out.visible = vis_e_ff;
      ctl_out.neg_x   = neg_x_ff;
      ctl_out.neg_y   = neg_y_ff;
      ctl_out.clip_w  = clip_e_ff;
   end

   assign rem_x_out = rem_x_ff;
   assign rem_y_out = rem_y_ff;
   assign den_out   = den_ff;

endmodule

>>> rtl/core/perspective_project_to_screen_unit.sv
// ----------------------------------------------------------------------------
// perspective_project_to_screen_unit
// Projects world points to screen pixels through a configured matrix.
// ----------------------------------------------------------------------------
// A request on the req_ channel carries one world point (x, y, z, signed
// fixed point). The unit forms clip x, y and w from three matrix columns,
// tests w against the near threshold, and divides by 2w in a chain of
// sixteen restoring-division cells, one quotient bit per cell, both pixel
// axes side by side. The rsp_ channel returns one result per request.
// The csr_ channel writes the matrix coefficients and the screen size; it is
// always ready and must only be used while no request is in flight.
// rsp_tvalid rises once the request has passed five front stages, sixteen
// divider cells and the output register; the first of these is loaded at
// the edge that accepts the request. A new request is accepted every cycle
// while the receiver does not stall.
// The whole pipeline advances together. When the receiver stalls with a
// result held in the output register, req_tready falls and every stage holds.
// Reset clears all valid bits and loads zero coefficients and a 1920 by 1080
// screen.
// ----------------------------------------------------------------------------
module perspective_project_to_screen_unit #(
   parameter int FRAC_BITS        = 16,
   parameter int NEAR_W_THRESHOLD = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // world_x, world_y, world_z
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [79:0]                        rsp_tdata,  // pixel_x, pixel_y, clip_w,
                                                          // centre_distance
   output logic [1:0]                         rsp_tuser,  // visible, on_screen
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppsu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [63:0]                        csr_data
);
   import ppsu_pkg::*;

   localparam int RW = PROD_W + 18 - FRAC_BITS;
   localparam int NCELL = QUOT_W;

   logic                  adv;
   logic [2:0][1:0][63:0] coef_ff;
   logic [12:0]           width_ff, height_ff;

   cell_ctl_type          ctl_c [NCELL+1];
   logic [RW-1:0]         rem_x_c [NCELL+1];
   logic [RW-1:0]         rem_y_c [NCELL+1];
   logic [RW-1:0]         den_c [NCELL+1];

   cell_ctl_type          fin;
   logic [14:0]           ux, uy;
   logic signed [15:0]    px, py;
   logic signed [16:0]    px_w, py_w, wid_s, hgt_s, dx, dy, adx, ady;
   logic                  ons;
   logic [15:0]           ctr_dist;

   logic                  rsp_valid_ff;
   logic [79:0]           rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEF_X_LO: coef_ff[0][0] <= csr_data;
            CSR_COEF_X_HI: coef_ff[0][1] <= csr_data;
            CSR_COEF_Y_LO: coef_ff[1][0] <= csr_data;
            CSR_COEF_Y_HI: coef_ff[1][1] <= csr_data;
            CSR_COEF_W_LO: coef_ff[2][0] <= csr_data;
            CSR_COEF_W_HI: coef_ff[2][1] <= csr_data;
            CSR_WIDTH:     width_ff      <= csr_data[12:0];
            CSR_HEIGHT:    height_ff     <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   ppsu_front #(
      .FRAC_BITS        (FRAC_BITS),
      .NEAR_W_THRESHOLD (NEAR_W_THRESHOLD),
      .RW               (RW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .point     ({req_tdata[95:64], req_tdata[63:32], req_tdata[31:0]}),
      .coef      (coef_ff),
      .width     (width_ff),
      .height    (height_ff),
      .ctl_out   (ctl_c[0]),
      .rem_x_out (rem_x_c[0]),
      .rem_y_out (rem_y_c[0]),
      .den_out   (den_c[0])
   );

   // Cell i settles quotient bit NCELL-1-i; the top bit flags overflow.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      ppsu_div_cell #(
         .RW  (RW),
         .BIT (NCELL - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .ctl_in    (ctl_c[i]),
         .rem_x_in  (rem_x_c[i]),
         .rem_y_in  (rem_y_c[i]),
         .den_in    (den_c[i]),
         .ctl_out   (ctl_c[i+1]),
         .rem_x_out (rem_x_c[i+1]),
         .rem_y_out (rem_y_c[i+1]),
         .den_out   (den_c[i+1])
      );
   end

   // Saturate the quotients, undo the sign folding, and derive the flags.
   always_comb begin
      fin   = ctl_c[NCELL];
      ux    = fin.quot_x[QUOT_W-1] ? 15'h7FFF : fin.quot_x[14:0];
      uy    = fin.quot_y[QUOT_W-1] ? 15'h7FFF : fin.quot_y[14:0];
      px    = fin.neg_x ? ~$signed({1'b0, ux}) : $signed({1'b0, ux});
      py    = fin.neg_y ? ~$signed({1'b0, uy}) : $signed({1'b0, uy});
      if (!fin.visible) begin
         px = '0;
         py = '0;
      end
      px_w  = 17'(px);
      py_w  = 17'(py);
      wid_s = $signed({4'b0, width_ff});
      hgt_s = $signed({4'b0, height_ff});
      ons   = fin.visible && !px[15] && px_w <= wid_s && !py[15] && py_w <= hgt_s;
      dx    = px_w - $signed({5'b0, width_ff[12:1]});
      dy    = py_w - $signed({5'b0, height_ff[12:1]});
      adx   = dx[16] ? -dx : dx;
      ady   = dy[16] ? -dy : dy;
      ctr_dist = (adx > ady) ? adx[15:0] : ady[15:0];
      if (!fin.visible) begin
         ctr_dist = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {ctr_dist, fin.clip_w, py, px};
         rsp_user_ff <= {ons, fin.visible};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A point behind the near plane never carries a pixel.
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0 && rsp_tdata[79:64] == 16'd0)
      else $error("hidden point carries pixel data");

   // On screen implies visible.
   a_onscreen_vis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("on_screen without visible");

   // An on-screen pixel lies inside the configured width.
   a_onscreen_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         !rsp_tdata[15] && rsp_tdata[15:0] <= {3'b0, width_ff})
      else $error("on_screen pixel outside width");

endmodule
